// ----- src/aes128_alt_key_schedule_macros.svh -----
// Assertion macros for the alternative key schedule block.
// Each macro expects clk and rst_n in scope.
`ifndef AES128_ALT_KEY_SCHEDULE_MACROS_SVH
`define AES128_ALT_KEY_SCHEDULE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define AKS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("key schedule check failed");

// Next-cycle implication, disabled during reset.
`define AKS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("key schedule check failed");

`endif

// ----- src/aks_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aks_pkg
// Shared types, constants and tables of the alternative AES-128 key schedule.
// ----------------------------------------------------------------------------
package aks_pkg;

    // Byte 0 sits in the most significant position of the packed vector.
    typedef logic [0:15][7:0] state_t;
    typedef logic [3:0]       round_t;

    localparam round_t ROUND_FIRST = 4'd0;
    localparam round_t ROUND_LAST  = 4'd10;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    localparam logic [7:0] SBOX_TAB [0:255] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] sbox(input logic [7:0] a);
        return SBOX_TAB[a];
    endfunction

    // Round constant for rounds 1 to 10; nothing is added in round 0.
    function automatic logic [7:0] rcon(input round_t rnd);
        logic [7:0] rc;
        case (rnd)
            4'd1:    rc = 8'h01;
            4'd2:    rc = 8'h02;
            4'd3:    rc = 8'h04;
            4'd4:    rc = 8'h08;
            4'd5:    rc = 8'h10;
            4'd6:    rc = 8'h20;
            4'd7:    rc = 8'h40;
            4'd8:    rc = 8'h80;
            4'd9:    rc = 8'h1b;
            4'd10:   rc = 8'h36;
            default: rc = 8'h00;
        endcase
        return rc;
    endfunction

endpackage

// ----- src/aes128_alt_key_schedule.sv -----
`timescale 1ns / 1ps
// The first round state of a key taken while idle passes through the queue and then the output register.
// The round engine gives eleven round states per key, one round state per cycle while out_stall is low.
// A new key follows the last round of the previous one with no gap.
// Reset (rst_n, asynchronous, active low) empties the queue and the output register.
// ----------------------------------------------------------------------------
// aes128_alt_key_schedule
// AES-128 key schedule in an alternative representation: eleven round states
// per key, rounds 0 to 10 in order.
// ----------------------------------------------------------------------------
module aes128_alt_key_schedule
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] key_upper,
    input  logic [63:0] key_lower,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  round_number,
    output logic [63:0] state_upper,
    output logic [63:0] state_lower,
    output logic        last_round
);
    import aks_pkg::*;

    `include "aes128_alt_key_schedule_macros.svh"

    // Front part: mix the key into the round-0 state and push it.
    // Queue: two entries, so the front keeps taking keys while the back works.
    // Back part: output register doubles as the round state; each output
    // transfer advances it by one round, or reloads it from the queue head
    // once round 10 has gone.

    q_status_t q_status;
    logic      push;
    state_t    push_state;
    logic      pop;
    state_t    head_state;

    aks_front u_front
    (
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .key_upper  (key_upper),
        .key_lower  (key_lower),
        .q_status   (q_status),
        .push       (push),
        .push_state (push_state)
    );

    aks_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_state (push_state),
        .pop        (pop),
        .head_state (head_state),
        .status     (q_status)
    );

    aks_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_status     (q_status),
        .head_state   (head_state),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .round_number (round_number),
        .state_upper  (state_upper),
        .state_lower  (state_lower),
        .last_round   (last_round)
    );

    // Rounds advance one by one within a key.
    `AKS_ASSERT_NEXT(a_round_step, out_valid && !out_stall && !last_round, out_valid && (round_number == 4'($past(round_number) + 4'd1)))

    // A key taken into an empty, idle block passes through the queue and the output register and appears as round 0.
    `AKS_ASSERT_NEXT(a_key_to_round0, in_valid && !in_stall && q_status.empty && !out_valid, ##1 (out_valid && (round_number == ROUND_FIRST)))

    // Never pop the queue while a key is still in flight.
    `AKS_ASSERT_NOW(a_pop_at_end, pop, !out_valid || (last_round && !out_stall))

endmodule

// ----- src/aks_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aks_front
// Input side: take a key transfer and push its round-0 state into the queue.
// ----------------------------------------------------------------------------
module aks_front
(
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [63:0]             key_upper,
    input  logic [63:0]             key_lower,
    input  aks_pkg::q_status_t      q_status,
    output logic                    push,
    output aks_pkg::state_t         push_state
);
    import aks_pkg::*;

    state_t k;
    state_t s;

    assign k = {key_upper, key_lower};

    // Round-0 mixing of the key bytes
    always_comb
    begin
        s[0]  = k[15];
        s[4]  = k[14];
        s[8]  = k[13];
        s[12] = k[12];
        s[1]  = k[14] ^ k[10] ^ k[6] ^ k[2];
        s[5]  = k[13] ^ k[9]  ^ k[5] ^ k[1];
        s[9]  = k[12] ^ k[8]  ^ k[4] ^ k[0];
        s[13] = k[15] ^ k[11] ^ k[7] ^ k[3];
        s[2]  = k[13] ^ k[5];
        s[6]  = k[12] ^ k[4];
        s[10] = k[15] ^ k[7];
        s[14] = k[14] ^ k[6];
        s[3]  = k[12] ^ k[8];
        s[7]  = k[15] ^ k[11];
        s[11] = k[14] ^ k[10];
        s[15] = k[13] ^ k[9];
    end

    assign in_stall   = q_status.full;
    assign push       = in_valid && !q_status.full;
    assign push_state = s;

endmodule

// ----- src/aks_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aks_queue
// Two-entry queue of round-0 states between the front and back parts.
// ----------------------------------------------------------------------------
module aks_queue
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  aks_pkg::state_t         push_state,
    input  logic                    pop,
    output aks_pkg::state_t         head_state,
    output aks_pkg::q_status_t      status
);
    import aks_pkg::*;

    state_t     entry_reg [0:1];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage: write only
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_state;
        end
    end

    assign head_state   = entry_reg[rd_ptr_reg];
    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);

endmodule

// ----- src/aks_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aks_back
// Round engine: step the state one round per transfer from the output register.
// ----------------------------------------------------------------------------
module aks_back
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  aks_pkg::q_status_t      q_status,
    input  aks_pkg::state_t         head_state,
    output logic                    pop,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [3:0]              round_number,
    output logic [63:0]             state_upper,
    output logic [63:0]             state_lower,
    output logic                    last_round
);
    import aks_pkg::*;

    localparam logic [3:0] COL_A = 4'd12;
    localparam logic [3:0] COL_B = 4'd13;
    localparam logic [3:0] COL_C = 4'd14;
    localparam logic [3:0] COL_D = 4'd15;

    // Four independent byte chains, then the round constant into byte 12.
    function automatic state_t next_round(input state_t p, input round_t rnd);
        state_t     n;
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] c;
        logic [7:0] d;
        for (int j = 0; j < 4; j++)
        begin
            a = p[COL_A + 4'(4 * j)];
            b = p[COL_B + 4'(4 * j)];
            c = p[COL_C + 4'(4 * j)];
            d = p[COL_D + 4'(4 * j)];
            n[4 * j]     = b ^ sbox(a);
            n[4 * j + 1] = c;
            n[4 * j + 2] = d;
            n[4 * j + 3] = a;
        end
        n[COL_A] = n[COL_A] ^ rcon(rnd);
        return n;
    endfunction

    logic   valid_reg;
    logic   valid_next;
    round_t round_reg;
    round_t round_next;
    state_t state_reg;
    state_t state_next;
    logic   advance;
    logic   busy;

    assign advance = !valid_reg || !out_stall;
    assign busy    = valid_reg && (round_reg != ROUND_LAST);
    assign pop     = advance && !busy && !q_status.empty;

    always_comb
    begin
        valid_next = valid_reg;
        round_next = round_reg;
        state_next = state_reg;
        if (advance)
        begin
            if (busy)
            begin
                round_next = round_reg + 4'd1;
                state_next = next_round(state_reg, round_reg + 4'd1);
                valid_next = 1'b1;
            end
            else if (!q_status.empty)
            begin
                round_next = ROUND_FIRST;
                state_next = head_state;
                valid_next = 1'b1;
            end
            else
            begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        round_reg <= round_next;
        state_reg <= state_next;
    end

    assign out_valid    = valid_reg;
    assign round_number = round_reg;
    assign state_upper  = state_reg[0:7];
    assign state_lower  = state_reg[8:15];
    assign last_round   = (round_reg == ROUND_LAST);

endmodule
